// ===== design/interpolating_sample_player_defines.svh =====
// assertion macros for the interpolating sample player checker
`ifndef INTERPOLATING_SAMPLE_PLAYER_DEFINES_SVH
`define INTERPOLATING_SAMPLE_PLAYER_DEFINES_SVH

// property that must hold in the same cycle as its trigger
`define ISP_ASSERT_SAME(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after its trigger
`define ISP_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/isp_pkg.sv =====
// shared types and constants for the interpolating sample player
`timescale 1ns / 1ps

package isp_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_TICK  = 2'd3
    } t_opcode;

    localparam logic [1:0] REG_SPEED = 2'd0;
    localparam logic [1:0] REG_LOOP  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    localparam int SPEED_W  = 24;
    localparam int COUNT_W  = 17;
    localparam int ADDR_W   = 16;
    localparam int VALUE_W  = 24;
    localparam int OUT_W    = 24;
    localparam int CH_OUT_W = 3;
    localparam int CFG_W    = 24;
    localparam int POS_W    = 34;
    localparam int FRAC_W   = 16;
    localparam int IDX_S_W  = 20;

    localparam logic signed [SPEED_W-1:0] SPEED_RESET = 24'sd65536;
    localparam logic signed [POS_W-1:0]   POS_ONE     = 34'sd65536;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = 3;

    typedef struct packed {
        logic                valid;
        logic                zero;
        logic [ADDR_W-1:0]   idx_a;
        logic [ADDR_W-1:0]   idx_b;
        logic [FRAC_W-1:0]   frac;
        logic [CH_OUT_W-1:0] channel;
        logic                last;
    } t_req;

    typedef struct packed {
        logic                valid;
        logic [OUT_W-1:0]    sample;
        logic [CH_OUT_W-1:0] channel;
        logic                last;
    } t_result;

endpackage

// ===== design/isp_mem.sv =====
// sample memory with one write port and two registered read ports
`timescale 1ns / 1ps

module isp_mem #(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [isp_pkg::ADDR_W-1:0] i_wr_addr,
    input  logic [SAMPLE_BITS-1:0]     i_wr_data,
    input  logic [isp_pkg::ADDR_W-1:0] i_rd_addr_a,
    input  logic [isp_pkg::ADDR_W-1:0] i_rd_addr_b,
    output logic [SAMPLE_BITS-1:0]     o_rd_a,
    output logic [SAMPLE_BITS-1:0]     o_rd_b
);

    localparam int AW = $clog2(MAX_SAMPLES);

    logic [SAMPLE_BITS-1:0] r_mem [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] r_rd_a;
    logic [SAMPLE_BITS-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[AW'(i_wr_addr)] <= i_wr_data;
        end
        r_rd_a <= r_mem[AW'(i_rd_addr_a)];
        r_rd_b <= r_mem[AW'(i_rd_addr_b)];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

// ===== design/isp_seq.sv =====
// command register, configuration, play position and per-channel read requests
`timescale 1ns / 1ps

module isp_seq #(
    parameter int MAX_SAMPLES = 65536,
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_opcode,
    input  logic [isp_pkg::ADDR_W-1:0]  i_sample_address,
    input  logic [isp_pkg::VALUE_W-1:0] i_sample_value,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [isp_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_space,
    output isp_pkg::t_req               o_req,
    output logic                        o_mem_we,
    output logic [isp_pkg::ADDR_W-1:0]  o_mem_addr,
    output logic [SAMPLE_BITS-1:0]      o_mem_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
    localparam logic signed [32:0] SAT_HI = 33'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;

    function automatic logic [isp_pkg::ADDR_W-1:0] clamp_idx(
        input logic signed [isp_pkg::IDX_S_W-1:0] idx,
        input logic signed [isp_pkg::IDX_S_W-1:0] hi
    );
        logic signed [isp_pkg::IDX_S_W-1:0] c;
        if (idx < 0) begin
            c = '0;
        end else if (idx > hi) begin
            c = hi;
        end else begin
            c = idx;
        end
        return c[isp_pkg::ADDR_W-1:0];
    endfunction

    logic                                r_in_valid;
    isp_pkg::t_opcode                    r_in_op;
    logic [isp_pkg::ADDR_W-1:0]          r_in_addr;
    logic signed [isp_pkg::VALUE_W-1:0]  r_in_value;
    logic signed [isp_pkg::SPEED_W-1:0]  r_speed;
    logic                                r_loop;
    logic [isp_pkg::COUNT_W-1:0]         r_count;
    logic signed [isp_pkg::POS_W-1:0]    r_pos;
    logic                                r_playing;
    logic [CH_W-1:0]                     r_ch;

    logic [isp_pkg::COUNT_W-1:0]         count_eff;
    logic signed [isp_pkg::IDX_S_W-1:0]  cnt_s;
    logic signed [isp_pkg::IDX_S_W-1:0]  cnt_m1;
    logic signed [isp_pkg::IDX_S_W-1:0]  i_old;
    logic signed [isp_pkg::IDX_S_W-1:0]  i_sum;
    logic signed [isp_pkg::IDX_S_W-1:0]  i_new;
    logic signed [isp_pkg::IDX_S_W-1:0]  idx_a;
    logic signed [isp_pkg::IDX_S_W-1:0]  idx_b;
    logic signed [isp_pkg::POS_W-1:0]    pos_sum;
    logic signed [isp_pkg::POS_W-1:0]    n_pos;
    logic                                n_playing;
    logic                                step_zero;
    logic                                active;
    logic                                issue;
    logic                                done;
    logic                                accept;
    logic signed [32:0]                  wr_ext;

    always_comb begin
        count_eff = (32'(r_count) > 32'(MAX_SAMPLES)) ? isp_pkg::COUNT_W'(MAX_SAMPLES)
                                                       : r_count;
        cnt_s   = signed'(isp_pkg::IDX_S_W'(count_eff));
        cnt_m1  = cnt_s - 20'sd1;
        i_old   = isp_pkg::IDX_S_W'(signed'(r_pos[isp_pkg::POS_W-1:isp_pkg::FRAC_W]));
        pos_sum = r_pos + isp_pkg::POS_W'(r_speed);
        i_sum   = isp_pkg::IDX_S_W'(signed'(pos_sum[isp_pkg::POS_W-1:isp_pkg::FRAC_W]));
        active  = r_playing && (count_eff != '0)
                  && (r_loop || (i_old >= 0 && i_old < cnt_s));

        n_pos     = r_pos;
        n_playing = r_playing;
        step_zero = 1'b1;
        idx_a     = '0;
        idx_b     = '0;

        if (active) begin
            if (r_loop && !r_speed[isp_pkg::SPEED_W-1]) begin
                n_pos = (i_sum >= cnt_m1) ? isp_pkg::POS_ONE : pos_sum;
            end else if (r_loop) begin
                n_pos = (pos_sum < 0) ? signed'({1'b0, count_eff, 16'b0}) : pos_sum;
            end else begin
                n_pos = pos_sum;
            end
        end

        i_new = isp_pkg::IDX_S_W'(signed'(n_pos[isp_pkg::POS_W-1:isp_pkg::FRAC_W]));

        if (active) begin
            if (r_loop && r_speed[isp_pkg::SPEED_W-1]) begin
                idx_a     = i_new - 20'sd1;
                idx_b     = i_new - 20'sd2;
                step_zero = 1'b0;
            end else if (r_loop || (i_new >= 0 && i_new < cnt_s)) begin
                idx_a     = i_new + 20'sd1;
                idx_b     = i_new + 20'sd2;
                step_zero = 1'b0;
            end else begin
                // one-shot play ran off the buffer
                n_playing = 1'b0;
            end
        end
    end

    assign issue   = r_in_valid && (r_in_op == isp_pkg::OP_TICK) && i_space;
    assign done    = r_in_valid && ((r_in_op != isp_pkg::OP_TICK)
                                    || (i_space && (r_ch == LAST_CH)));
    assign o_stall = r_in_valid && !done;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        o_req.valid   = issue;
        o_req.zero    = step_zero;
        o_req.idx_a   = clamp_idx(idx_a, cnt_m1);
        o_req.idx_b   = clamp_idx(idx_b, cnt_m1);
        o_req.frac    = n_pos[isp_pkg::FRAC_W-1:0];
        o_req.channel = isp_pkg::CH_OUT_W'(r_ch);
        o_req.last    = (r_ch == LAST_CH);
    end

    // sample write, saturated to the stored width
    always_comb begin
        wr_ext = 33'(r_in_value);
        if (wr_ext > SAT_HI) begin
            wr_ext = SAT_HI;
        end else if (wr_ext < SAT_LO) begin
            wr_ext = SAT_LO;
        end
        o_mem_data = SAMPLE_BITS'(wr_ext);
        o_mem_addr = r_in_addr;
        o_mem_we   = r_in_valid && (r_in_op == isp_pkg::OP_WRITE)
                     && (32'(r_in_addr) < 32'(MAX_SAMPLES));
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_op    <= isp_pkg::t_opcode'(i_opcode);
            r_in_addr  <= i_sample_address;
            r_in_value <= i_sample_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_speed    <= isp_pkg::SPEED_RESET;
            r_loop     <= 1'b0;
            r_count    <= '0;
            r_pos      <= '0;
            r_playing  <= 1'b0;
            r_ch       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    isp_pkg::REG_SPEED: r_speed <= i_cfg_data;
                    isp_pkg::REG_LOOP:  r_loop  <= i_cfg_data[0];
                    isp_pkg::REG_COUNT: r_count <= i_cfg_data[isp_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (done) begin
                r_in_valid <= 1'b0;
            end

            if (r_in_valid) begin
                case (r_in_op)
                    isp_pkg::OP_START: begin
                        r_playing <= 1'b1;
                        r_pos     <= '0;
                    end
                    isp_pkg::OP_STOP: begin
                        r_playing <= 1'b0;
                    end
                    isp_pkg::OP_TICK: begin
                        if (issue) begin
                            r_pos     <= n_pos;
                            r_playing <= n_playing;
                            r_ch      <= (r_ch == LAST_CH) ? '0 : r_ch + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== design/isp_interp.sv =====
// weighting multipliers and rounding of two neighbouring samples
`timescale 1ns / 1ps

module isp_interp #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  isp_pkg::t_req          i_req,
    input  logic [SAMPLE_BITS-1:0] i_rd_a,
    input  logic [SAMPLE_BITS-1:0] i_rd_b,
    output isp_pkg::t_result       o_result
);

    localparam int PROD_W = SAMPLE_BITS + 18;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = SUM_W - isp_pkg::FRAC_W;
    localparam logic signed [Q_W-1:0] Q_HI = Q_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [Q_W-1:0] Q_LO = -Q_HI - Q_W'(1);

    logic                                r_s1_valid;
    logic                                r_s1_zero;
    logic [isp_pkg::FRAC_W-1:0]          r_s1_frac;
    logic [isp_pkg::CH_OUT_W-1:0]        r_s1_ch;
    logic                                r_s1_last;
    logic                                r_s2_valid;
    logic signed [PROD_W-1:0]            r_s2_pa;
    logic signed [PROD_W-1:0]            r_s2_pb;
    logic [isp_pkg::CH_OUT_W-1:0]        r_s2_ch;
    logic                                r_s2_last;

    logic signed [SAMPLE_BITS-1:0]       va;
    logic signed [SAMPLE_BITS-1:0]       vb;
    logic signed [17:0]                  wa;
    logic signed [17:0]                  wb;
    logic signed [SUM_W-1:0]             sum;
    logic signed [Q_W-1:0]               q;
    logic signed [SAMPLE_BITS-1:0]       q_sat;

    always_comb begin
        va = signed'(i_rd_a);
        vb = signed'(i_rd_b);
        wa = signed'(18'(18'h10000 - {2'b0, r_s1_frac}));
        wb = signed'({2'b0, r_s1_frac});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_req.valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_zero <= i_req.zero;
        r_s1_frac <= i_req.frac;
        r_s1_ch   <= i_req.channel;
        r_s1_last <= i_req.last;
        r_s2_ch   <= r_s1_ch;
        r_s2_last <= r_s1_last;
        if (r_s1_zero) begin
            r_s2_pa <= '0;
            r_s2_pb <= '0;
        end else begin
            r_s2_pa <= va * wa;
            r_s2_pb <= vb * wb;
        end
    end

    // floor division by one in Q16, then clip to the stored sample range
    always_comb begin
        sum = SUM_W'(r_s2_pa) + SUM_W'(r_s2_pb);
        q   = signed'(sum[SUM_W-1:isp_pkg::FRAC_W]);
        if (q > Q_HI) begin
            q_sat = SAMPLE_BITS'(Q_HI);
        end else if (q < Q_LO) begin
            q_sat = SAMPLE_BITS'(Q_LO);
        end else begin
            q_sat = SAMPLE_BITS'(q);
        end
        o_result.valid   = r_s2_valid;
        o_result.sample  = isp_pkg::OUT_W'(q_sat);
        o_result.channel = r_s2_ch;
        o_result.last    = r_s2_last;
    end

endmodule

// ===== design/isp_queue.sv =====
// result queue with slot reservation for results still in the pipeline
`timescale 1ns / 1ps

module isp_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_issue,
    input  isp_pkg::t_result              i_result,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [isp_pkg::OUT_W-1:0]     o_sample_out,
    output logic [isp_pkg::CH_OUT_W-1:0]  o_channel,
    output logic                          o_last,
    output logic                          o_space
);

    localparam int CW = isp_pkg::QUEUE_AW + 1;

    logic [isp_pkg::OUT_W-1:0]    r_q_sample [isp_pkg::QUEUE_DEPTH];
    logic [isp_pkg::CH_OUT_W-1:0] r_q_ch     [isp_pkg::QUEUE_DEPTH];
    logic                         r_q_last   [isp_pkg::QUEUE_DEPTH];
    logic [isp_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [isp_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [CW-1:0]                r_fill;
    logic [CW-1:0]                r_used;
    logic                         pop;

    assign o_valid      = (r_fill != '0);
    assign pop          = o_valid && !i_stall;
    assign o_space      = (r_used != CW'(isp_pkg::QUEUE_DEPTH));
    assign o_sample_out = r_q_sample[r_rd_ptr];
    assign o_channel    = r_q_ch[r_rd_ptr];
    assign o_last       = r_q_last[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_q_sample[r_wr_ptr] <= i_result.sample;
            r_q_ch[r_wr_ptr]     <= i_result.channel;
            r_q_last[r_wr_ptr]   <= i_result.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_used   <= '0;
        end else begin
            if (i_result.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fill <= r_fill + CW'(i_result.valid) - CW'(pop);
            r_used <= r_used + CW'(i_issue) - CW'(pop);
        end
    end

endmodule

// ===== design/interpolating_sample_player.sv =====
// top level of the interpolating sample player
`timescale 1ns / 1ps

// Sample writes, start and stop never stall; a tick serves the channels one at a time,
// because each channel steps the shared play position and issues one read on each of the two
// sample memory ports. A new command can be taken every cycle unless a tick is still issuing
// its channels. Each channel result passes the memory read and interpolator registers into
// an eight-entry output queue; a channel is only issued when a queue slot is free, so output
// stall holds back ticks but never the internal pipeline. The sample memory has no reset and
// is not cleared: reading a sample that was never written gives an undefined value.

module interpolating_sample_player #(
    parameter int MAX_SAMPLES = 65536,
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [isp_pkg::ADDR_W-1:0]    i_sample_address,
    input  logic [isp_pkg::VALUE_W-1:0]   i_sample_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [isp_pkg::OUT_W-1:0]     o_sample_out,
    output logic [isp_pkg::CH_OUT_W-1:0]  o_channel,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [isp_pkg::CFG_W-1:0]     i_cfg_data
);

    isp_pkg::t_req              req;
    isp_pkg::t_result           result;
    logic                       space;
    logic                       mem_we;
    logic [isp_pkg::ADDR_W-1:0] mem_addr;
    logic [SAMPLE_BITS-1:0]     mem_data;
    logic [SAMPLE_BITS-1:0]     rd_a;
    logic [SAMPLE_BITS-1:0]     rd_b;

    isp_seq #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_sample_address (i_sample_address),
        .i_sample_value   (i_sample_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_space          (space),
        .o_req            (req),
        .o_mem_we         (mem_we),
        .o_mem_addr       (mem_addr),
        .o_mem_data       (mem_data)
    );

    isp_mem #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mem (
        .i_clk       (i_clk),
        .i_we        (mem_we),
        .i_wr_addr   (mem_addr),
        .i_wr_data   (mem_data),
        .i_rd_addr_a (req.idx_a),
        .i_rd_addr_b (req.idx_b),
        .o_rd_a      (rd_a),
        .o_rd_b      (rd_b)
    );

    isp_interp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .i_rd_a   (rd_a),
        .i_rd_b   (rd_b),
        .o_result (result)
    );

    isp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_issue      (req.valid),
        .i_result     (result),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_sample_out (o_sample_out),
        .o_channel    (o_channel),
        .o_last       (o_last),
        .o_space      (space)
    );

endmodule

// ===== design/isp_checker.sv =====
// port-level assertion checker for the interpolating sample player
`timescale 1ns / 1ps
`include "interpolating_sample_player_defines.svh"

module isp_checker #(
    parameter int CHANNELS = 2
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [23:0] o_sample_out,
    input logic [2:0]  o_channel,
    input logic        o_last
);

    // a held result keeps its contents
    `ISP_ASSERT_NEXT(a_hold, i_clk, !i_rst_n, o_valid && i_stall, o_valid && $stable(o_sample_out) && $stable(o_channel) && $stable(o_last), "result changed while stalled")

    // last flag marks exactly the final channel
    `ISP_ASSERT_SAME(a_last_ch, i_clk, !i_rst_n, o_valid, o_last == (o_channel == 3'(CHANNELS - 1)), "last flag and channel disagree")

    // channels of one tick follow each other without gaps
    `ISP_ASSERT_NEXT(a_ch_order, i_clk, !i_rst_n, o_valid && !i_stall && !o_last, o_valid && (o_channel == $past(o_channel) + 3'd1), "channel sequence broken")

    // reset empties the output
    `ISP_ASSERT_NEXT(a_reset, i_clk, 1'b0, !i_rst_n, !o_valid, "result valid after reset")

endmodule

bind interpolating_sample_player isp_checker #(
    .CHANNELS (CHANNELS)
) u_isp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_sample_out (o_sample_out),
    .o_channel    (o_channel),
    .o_last       (o_last)
);

// ===== tb/tb_interpolating_sample_player.sv =====
// testbench for the interpolating sample player: every output transfer checked against a predictor
`timescale 1ns / 1ps

module tb_interpolating_sample_player;

    localparam int MAX_SAMPLES    = 65536;
    localparam int CHANNELS       = 2;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TIMEOUT_NS     = 2_000_000;

    typedef struct {
        logic [isp_pkg::OUT_W-1:0]    sample;
        logic [isp_pkg::CH_OUT_W-1:0] channel;
        logic                         last;
    } t_pcm;

    logic                         i_clk            = 1'b0;
    logic                         i_rst_n          = 1'b0;
    logic                         i_valid          = 1'b0;
    logic                         o_stall;
    logic [1:0]                   i_opcode         = isp_pkg::OP_WRITE;
    logic [isp_pkg::ADDR_W-1:0]   i_sample_address = '0;
    logic [isp_pkg::VALUE_W-1:0]  i_sample_value   = '0;
    logic                         o_valid;
    logic                         i_stall          = 1'b0;
    logic [isp_pkg::OUT_W-1:0]    o_sample_out;
    logic [isp_pkg::CH_OUT_W-1:0] o_channel;
    logic                         o_last;
    logic                         i_cfg_we         = 1'b0;
    logic [1:0]                   i_cfg_index      = isp_pkg::REG_SPEED;
    logic [isp_pkg::CFG_W-1:0]    i_cfg_data       = '0;

    // predictor state
    logic signed [isp_pkg::VALUE_W-1:0] sample_store [MAX_SAMPLES];
    bit                                 sample_written [MAX_SAMPLES];
    logic signed [isp_pkg::POS_W-1:0]   model_pos     = '0;
    logic                               model_playing = 1'b0;
    logic signed [isp_pkg::SPEED_W-1:0] model_speed   = isp_pkg::SPEED_RESET;
    logic                               model_loop    = 1'b0;
    logic [isp_pkg::COUNT_W-1:0]        model_count   = '0;

    t_pcm expected_pcm [$];
    int   missing_addr [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holdoff_asked = 0;
    int holdoff_seen  = 0;
    int holdoff_left  = 0;

    int items_sent = 0;
    int n_ticks    = 0;
    int n_writes   = 0;
    int n_ctrl     = 0;
    int n_settings = 0;
    int n_checked  = 0;
    int err_count  = 0;

    interpolating_sample_player i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_sample_address (i_sample_address),
        .i_sample_value   (i_sample_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_sample_out     (o_sample_out),
        .o_channel        (o_channel),
        .o_last           (o_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL interpolating_sample_player");
        $finish;
    end

    function automatic longint clamp_index(input longint idx, input longint cnt);
        if (idx < 0) return 0;
        if (idx > cnt - 1) return cnt - 1;
        return idx;
    endfunction

    function automatic logic [isp_pkg::OUT_W-1:0] blend(input longint ia, input longint ib,
                                                        input longint frac);
        longint va, vb, s, q;
        va = longint'(sample_store[ia]);
        vb = longint'(sample_store[ib]);
        s  = va * (65536 - frac) + vb * frac;
        q  = s >>> isp_pkg::FRAC_W;
        if (q > 8388607) q = 8388607;
        else if (q < -8388608) q = -8388608;
        return isp_pkg::OUT_W'(q);
    endfunction

    // one tick of all channels; a dry run only lists the unwritten words it would read
    function automatic void predict_tick(input bit commit);
        logic signed [isp_pkg::POS_W-1:0] pos;
        logic                             play;
        longint                           cnt, idx, frac, ia, ib;
        logic [isp_pkg::OUT_W-1:0]        val;
        bit                               fetch;
        t_pcm                             res;
        pos  = model_pos;
        play = model_playing;
        cnt  = (model_count > MAX_SAMPLES) ? MAX_SAMPLES : longint'(model_count);
        frac = 0;
        ia   = 0;
        ib   = 0;
        missing_addr.delete();
        for (int ch = 0; ch < CHANNELS; ch++) begin
            val   = '0;
            fetch = 1'b0;
            idx   = longint'(pos >>> isp_pkg::FRAC_W);
            if (play && cnt != 0 && (model_loop || (idx >= 0 && idx < cnt))) begin
                pos = pos + model_speed;
                if (model_loop && !model_speed[isp_pkg::SPEED_W-1]) begin
                    if (longint'(pos >>> isp_pkg::FRAC_W) >= cnt - 1) pos = isp_pkg::POS_ONE;
                end else if (model_loop && pos < 0) begin
                    pos = isp_pkg::POS_W'(cnt * 65536);
                end
                idx  = longint'(pos >>> isp_pkg::FRAC_W);
                frac = longint'(pos[isp_pkg::FRAC_W-1:0]);
                if (model_loop && model_speed[isp_pkg::SPEED_W-1]) begin
                    ia    = idx - 1;
                    ib    = idx - 2;
                    fetch = 1'b1;
                end else if (model_loop || (idx >= 0 && idx < cnt)) begin
                    ia    = idx + 1;
                    ib    = idx + 2;
                    fetch = 1'b1;
                end else begin
                    play = 1'b0;
                end
            end
            if (fetch) begin
                ia = clamp_index(ia, cnt);
                ib = clamp_index(ib, cnt);
                if (commit) begin
                    val = blend(ia, ib, frac);
                end else begin
                    if (!sample_written[ia]) missing_addr.push_back(int'(ia));
                    if (!sample_written[ib]) missing_addr.push_back(int'(ib));
                end
            end
            if (commit) begin
                res.sample  = val;
                res.channel = isp_pkg::CH_OUT_W'(ch);
                res.last    = (ch == CHANNELS - 1);
                expected_pcm.push_back(res);
            end
        end
        if (commit) begin
            model_pos     = pos;
            model_playing = play;
        end
    endfunction

    function automatic logic [isp_pkg::VALUE_W-1:0] rand_sample();
        case ($urandom_range(15))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return '0;
            default: return isp_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input isp_pkg::t_opcode op,
                             input logic [isp_pkg::ADDR_W-1:0] addr,
                             input logic [isp_pkg::VALUE_W-1:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid          <= 1'b1;
        i_opcode         <= op;
        i_sample_address <= addr;
        i_sample_value   <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        case (op)
            isp_pkg::OP_WRITE: begin
                sample_store[addr]   = value;
                sample_written[addr] = 1'b1;
                n_writes++;
            end
            isp_pkg::OP_START: begin
                model_playing = 1'b1;
                model_pos     = '0;
                n_ctrl++;
            end
            isp_pkg::OP_STOP: begin
                model_playing = 1'b0;
                n_ctrl++;
            end
            default: begin
                predict_tick(1'b1);
                n_ticks++;
            end
        endcase
    endtask

    // fill in any word the tick would read before it was ever written
    task automatic send_tick();
        int addr_list [$];
        predict_tick(1'b0);
        addr_list = missing_addr;
        foreach (addr_list[k]) begin
            if (!sample_written[addr_list[k]])
                send_item(isp_pkg::OP_WRITE, isp_pkg::ADDR_W'(addr_list[k]), rand_sample());
        end
        send_item(isp_pkg::OP_TICK, isp_pkg::ADDR_W'($urandom), isp_pkg::VALUE_W'($urandom));
    endtask

    task automatic send_ctrl(input isp_pkg::t_opcode op);
        send_item(op, isp_pkg::ADDR_W'($urandom), isp_pkg::VALUE_W'($urandom));
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (expected_pcm.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic signed [isp_pkg::SPEED_W-1:0] spd,
                                  input logic lp,
                                  input logic [isp_pkg::COUNT_W-1:0] cnt);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= isp_pkg::REG_SPEED;
        i_cfg_data  <= spd;
        @(posedge i_clk);
        model_speed = spd;
        i_cfg_index <= isp_pkg::REG_LOOP;
        i_cfg_data  <= isp_pkg::CFG_W'(lp);
        @(posedge i_clk);
        model_loop = lp;
        i_cfg_index <= isp_pkg::REG_COUNT;
        i_cfg_data  <= isp_pkg::CFG_W'(cnt);
        @(posedge i_clk);
        model_count = cnt;
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    always @(posedge i_clk) begin
        if (holdoff_seen != holdoff_asked) begin
            holdoff_seen = holdoff_asked;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left != 0) begin
            holdoff_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_transfers
        t_pcm want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pcm.size() == 0) begin
                $error("unexpected transfer: sample_out %0d channel %0d last %0d",
                       $signed(o_sample_out), o_channel, o_last);
                err_count++;
            end else begin
                want = expected_pcm.pop_front();
                n_checked++;
                if (o_sample_out !== want.sample) begin
                    $error("sample_out expected %0d got %0d",
                           $signed(want.sample), $signed(o_sample_out));
                    err_count++;
                end
                if (o_channel !== want.channel) begin
                    $error("channel expected %0d got %0d", want.channel, o_channel);
                    err_count++;
                end
                if (o_last !== want.last) begin
                    $error("last expected %0d got %0d", want.last, o_last);
                    err_count++;
                end
            end
        end
    end

    task automatic test_idle_ticks();
        send_tick();
        send_ctrl(isp_pkg::OP_START);
        send_tick();
    endtask

    // one-shot end reached by channel 0, channel 1 follows with zero
    task automatic test_oneshot_end();
        write_settings(98304, 1'b0, 4);
        send_item(isp_pkg::OP_WRITE, 16'd0, rand_sample());
        send_item(isp_pkg::OP_WRITE, 16'd1, rand_sample());
        send_item(isp_pkg::OP_WRITE, 16'd2, 24'h800000);
        send_item(isp_pkg::OP_WRITE, 16'd3, 24'h7FFFFF);
        send_item(isp_pkg::OP_WRITE, 16'hFFFF, 24'h7FFFFF);
        send_ctrl(isp_pkg::OP_START);
        repeat (3) send_tick();
    endtask

    task automatic test_reverse_oneshot();
        write_settings(-65536, 1'b0, 4);
        send_ctrl(isp_pkg::OP_START);
        send_tick();
    endtask

    task automatic test_loop_wrap();
        write_settings(65536, 1'b1, 4);
        send_ctrl(isp_pkg::OP_START);
        repeat (3) send_tick();
        write_settings(-49152, 1'b1, 4);
        send_ctrl(isp_pkg::OP_START);
        repeat (2) send_tick();
    endtask

    // position left beyond a shortened buffer
    task automatic test_position_outside();
        write_settings(196608, 1'b1, 8);
        send_ctrl(isp_pkg::OP_START);
        send_tick();
        write_settings(196608, 1'b0, 4);
        send_tick();
        write_settings(65536, 1'b0, 8);
        send_tick();
        send_ctrl(isp_pkg::OP_STOP);
        send_tick();
    endtask

    task automatic test_large_count();
        write_settings(-8388608, 1'b1, 131071);
        send_ctrl(isp_pkg::OP_START);
        send_tick();
        write_settings(8388607, 1'b0, 65536);
        send_ctrl(isp_pkg::OP_START);
        repeat (2) send_tick();
    endtask

    task automatic test_output_holdoff();
        int saved_send, saved_recv;
        saved_send = send_idle_pct;
        saved_recv = recv_idle_pct;
        write_settings(19661, 1'b1, 16);
        for (int k = 0; k < 16; k++)
            send_item(isp_pkg::OP_WRITE, isp_pkg::ADDR_W'(k), rand_sample());
        send_ctrl(isp_pkg::OP_START);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holdoff_asked <= holdoff_asked + 1;
        repeat (40) send_tick();
        settle();
        send_idle_pct = saved_send;
        recv_idle_pct = saved_recv;
    endtask

    task automatic test_random_playback(input int send_pct, input int recv_pct,
                                        input int n_items);
        int                                 stop_at, n_buf, roll;
        longint                             span;
        logic [isp_pkg::COUNT_W-1:0]        cnt;
        logic signed [isp_pkg::SPEED_W-1:0] spd;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            roll = $urandom_range(19);
            if (roll == 0) cnt = 0;
            else if (roll == 1) cnt = 65536;
            else if (roll <= 3) cnt = isp_pkg::COUNT_W'($urandom_range(65537, 131071));
            else if (roll <= 5) cnt = isp_pkg::COUNT_W'($urandom_range(17, 64));
            else cnt = isp_pkg::COUNT_W'($urandom_range(1, 16));
            case ($urandom_range(9))
                0, 1:    spd = isp_pkg::SPEED_W'(int'($urandom_range(1, 3)) * 65536);
                2, 3:    spd = isp_pkg::SPEED_W'(int'($urandom_range(1, 131072)));
                4, 5:    spd = isp_pkg::SPEED_W'(-int'($urandom_range(1, 131072)));
                6:       spd = isp_pkg::SPEED_W'(-int'($urandom_range(1, 3)) * 65536);
                7:       spd = isp_pkg::SPEED_W'($urandom);
                8:       spd = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
                default: spd = '0;
            endcase
            write_settings(spd, 1'($urandom_range(1)), cnt);
            span  = (cnt > MAX_SAMPLES) ? MAX_SAMPLES : longint'(cnt);
            n_buf = (span > 20) ? 20 : int'(span);
            for (int k = 0; k < n_buf; k++)
                send_item(isp_pkg::OP_WRITE, isp_pkg::ADDR_W'(k), rand_sample());
            send_ctrl(isp_pkg::OP_START);
            repeat ($urandom_range(4, 30)) begin
                roll = $urandom_range(99);
                if (roll < 72) begin
                    send_tick();
                end else if (roll < 84) begin
                    send_item(isp_pkg::OP_WRITE,
                              isp_pkg::ADDR_W'($urandom_range(0,
                                  (span > 0) ? int'(span) - 1 : 0)),
                              rand_sample());
                end else if (roll < 90) begin
                    send_ctrl(isp_pkg::OP_START);
                end else if (roll < 95) begin
                    send_ctrl(isp_pkg::OP_STOP);
                end else begin
                    send_item(isp_pkg::OP_WRITE, isp_pkg::ADDR_W'($urandom), rand_sample());
                end
            end
        end
    endtask

    initial begin
        while (!i_rst_n) @(posedge i_clk);
        send_idle_pct = 22;
        recv_idle_pct = 73;
        test_idle_ticks();
        test_oneshot_end();
        test_reverse_oneshot();
        test_loop_wrap();
        test_position_outside();
        test_large_count();
        test_output_holdoff();
        test_random_playback(22, 73, 380);
        test_random_playback(73, 22, 380);
        test_random_playback(0, 0, 370);
        settle();
        $display("covered %0d ticks, %0d sample writes, %0d start/stop commands, %0d settings",
                 n_ticks, n_writes, n_ctrl, n_settings);
        $display("%0d output transfers checked, %0d mismatches", n_checked, err_count);
        if (err_count == 0 && expected_pcm.size() == 0) begin
            $display("PASS interpolating_sample_player");
        end else begin
            $display("FAIL interpolating_sample_player");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/isp_pkg.sv
design/isp_mem.sv
design/isp_seq.sv
design/isp_interp.sv
design/isp_queue.sv
design/interpolating_sample_player.sv
design/isp_checker.sv
tb/tb_interpolating_sample_player.sv
